/* hw/rtl/cmyk_pkg.sv */
package cmyk_pkg;

  localparam logic [7:0] CMax = 8'hFF;

  localparam logic [1:0] CompCyan    = 2'd0;
  localparam logic [1:0] CompMagenta = 2'd1;
  localparam logic [1:0] CompYellow  = 2'd2;
  localparam logic [1:0] CompBlack   = 2'd3;

  localparam int DivSteps = 8;
  localparam int StepW = $clog2(DivSteps);
  localparam logic [StepW-1:0] LastStep = StepW'(DivSteps - 1);

  typedef struct packed {
    logic       hold;
    logic       hold_sel;
    logic       capture;
    logic       div_load;
    logic       div_step;
    logic       out_load;
    logic [1:0] comp;
  } cmyk_cmd_t;

  typedef struct packed {
    logic div_done;
  } cmyk_sts_t;

endpackage

/* hw/rtl/rgb_to_cmyk_byte_stream_core.sv */
// RGB to CMYK byte stream converter. Feed red, green and blue bytes in turn
// on in_byte; after each blue byte the core emits four beats, cyan, magenta,
// yellow and black, with last set on the black beat. Red and green beats are
// taken one per cycle. The blue beat starts three divisions of 255*(inv-K)
// by 255-K on one shared restoring divider that retires one quotient bit per
// cycle; each of C, M and Y is loaded, divided and then registered as an
// output beat, and K is registered through the finish state without a
// division once yellow is taken. No new byte is accepted until the black
// beat of the current pixel has been taken.
module rgb_to_cmyk_byte_stream_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic [1:0] component,
  output logic       last
);
  import cmyk_pkg::*;

  cmyk_cmd_t cmd;
  cmyk_sts_t sts;

  cmyk_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  cmyk_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_byte   (in_byte),
    .cmd       (cmd),
    .sts       (sts),
    .out_byte  (out_byte),
    .component (component),
    .last      (last)
  );

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input and output both open");

  a_last_on_black: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (last == (component == CompBlack)))
    else $error("last not aligned with black beat");

  a_back_to_input: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && last |=> in_ready)
    else $error("input not reopened after pixel");

  a_gap_between_beats: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last |=> !out_valid)
    else $error("next component beat presented too early");

endmodule

/* hw/rtl/cmyk_dp.sv */
module cmyk_dp (
  input  logic              clk,
  input  logic              rst,
  input  logic [7:0]        in_byte,
  input  cmyk_pkg::cmyk_cmd_t cmd,
  output cmyk_pkg::cmyk_sts_t sts,
  output logic [7:0]        out_byte,
  output logic [1:0]        component,
  output logic              last
);
  import cmyk_pkg::*;

  logic [7:0] held_red;
  logic [7:0] held_green;
  logic [7:0] inv_c;
  logic [7:0] inv_m;
  logic [7:0] inv_y;
  logic [7:0] kval;
  logic       span_zero;
  logic [7:0] rem;
  logic [7:0] quo;
  logic [StepW-1:0] step_cnt;

  logic [7:0]  cap_c;
  logic [7:0]  cap_m;
  logic [7:0]  cap_y;
  logic [7:0]  cap_k;
  logic [7:0]  sel_inv;
  logic [7:0]  diff;
  logic [15:0] num;
  logic [8:0]  trial;
  logic [8:0]  span;
  logic        ge;

  // inverted component: 255 - x is the bitwise complement
  assign cap_c = ~held_red;
  assign cap_m = ~held_green;
  assign cap_y = ~in_byte;

  always_comb begin
    cap_k = cap_c;
    if (cap_m < cap_k) cap_k = cap_m;
    if (cap_y < cap_k) cap_k = cap_y;
  end

  always_comb begin
    case (cmd.comp)
      CompCyan:    sel_inv = inv_c;
      CompMagenta: sel_inv = inv_m;
      default:     sel_inv = inv_y;
    endcase
  end

  // 255 * diff as (diff << 8) - diff
  assign diff  = sel_inv - kval;
  assign num   = {diff, 8'h00} - {8'h00, diff};
  assign span  = {1'b0, ~kval};
  assign trial = {rem, quo[7]};
  assign ge    = (trial >= span);

  assign sts.div_done = (step_cnt == LastStep);

  always_ff @(posedge clk) begin
    if (rst) begin
      step_cnt <= '0;
    end else if (cmd.div_load) begin
      step_cnt <= '0;
    end else if (cmd.div_step) begin
      step_cnt <= step_cnt + StepW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.hold) begin
      if (cmd.hold_sel) held_green <= in_byte;
      else held_red <= in_byte;
    end
    if (cmd.capture) begin
      inv_c     <= cap_c;
      inv_m     <= cap_m;
      inv_y     <= cap_y;
      kval      <= cap_k;
      span_zero <= (cap_k == CMax);
    end
    // dividend high byte is already below the divisor, so eight steps suffice
    if (cmd.div_load) begin
      rem <= num[15:8];
      quo <= num[7:0];
    end else if (cmd.div_step) begin
      rem <= ge ? 8'(trial - span) : trial[7:0];
      quo <= {quo[6:0], ge};
    end
    if (cmd.out_load) begin
      component <= cmd.comp;
      last      <= (cmd.comp == CompBlack);
      if (cmd.comp == CompBlack) out_byte <= kval;
      else if (span_zero) out_byte <= 8'h00;
      else out_byte <= quo;
    end
  end

endmodule

/* hw/rtl/cmyk_ctrl.sv */
module cmyk_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  cmyk_pkg::cmyk_sts_t sts,
  output cmyk_pkg::cmyk_cmd_t cmd
);
  import cmyk_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_DIV,
    S_FINISH,
    S_OUT
  } state_t;

  state_t     state;
  logic [1:0] pos;
  logic [1:0] comp;
  logic       in_fire;

  assign in_ready = (state == S_IDLE);
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    cmd          = '0;
    cmd.hold     = in_fire && !pos[1];
    cmd.hold_sel = pos[0];
    cmd.capture  = in_fire && pos[1];
    cmd.div_load = (state == S_LOAD);
    cmd.div_step = (state == S_DIV);
    cmd.out_load = (state == S_FINISH);
    cmd.comp     = comp;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      pos       <= 2'd0;
      comp      <= CompCyan;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_fire) begin
            // a stray position of three is taken as the blue byte
            if (pos[1]) begin
              pos   <= 2'd0;
              comp  <= CompCyan;
              state <= S_LOAD;
            end else begin
              pos <= pos + 2'd1;
            end
          end
        end
        S_LOAD: state <= S_DIV;
        S_DIV: begin
          if (sts.div_done) state <= S_FINISH;
        end
        S_FINISH: begin
          out_valid <= 1'b1;
          state     <= S_OUT;
        end
        S_OUT: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            if (comp == CompBlack) begin
              state <= S_IDLE;
            end else if (comp == CompYellow) begin
              comp  <= CompBlack;
              state <= S_FINISH;
            end else begin
              comp  <= comp + 2'd1;
              state <= S_LOAD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* sim/tb_rgb_to_cmyk_byte_stream_core.sv */
`timescale 1ns / 1ps

module tb_rgb_to_cmyk_byte_stream_core;
  import cmyk_pkg::*;

  typedef struct {
    logic [7:0] value;
    logic [1:0] comp;
    logic       last;
  } cmyk_beat_t;

  class cmyk_scoreboard;
    cmyk_beat_t  pending_beats[$];
    logic [7:0]  held_red;
    logic [7:0]  held_green;
    int unsigned byte_pos;
    int unsigned errors;
    int unsigned beats_seen;
    int unsigned pixels_done;
    int unsigned black_pixels;

    function new();
      held_red     = '0;
      held_green   = '0;
      byte_pos     = 0;
      errors       = 0;
      beats_seen   = 0;
      pixels_done  = 0;
      black_pixels = 0;
    endfunction

    // 255*(inv-k)/(255-k), truncated; zero when k is full scale
    function logic [7:0] scale_ink(int unsigned inv, int unsigned k);
      int unsigned span;
      span = 255 - k;
      if (span == 0) begin
        return 8'd0;
      end
      return 8'((255 * (inv - k)) / span);
    endfunction

    function void note_byte(logic [7:0] b);
      int unsigned inv_c;
      int unsigned inv_m;
      int unsigned inv_y;
      int unsigned k;
      logic [1:0]  comps[4];
      logic [7:0]  vals[4];
      cmyk_beat_t  beat;
      if (byte_pos == 0) begin
        held_red = b;
        byte_pos = 1;
        return;
      end
      if (byte_pos == 1) begin
        held_green = b;
        byte_pos   = 2;
        return;
      end
      byte_pos = 0;
      inv_c = 255 - held_red;
      inv_m = 255 - held_green;
      inv_y = 255 - b;
      k = inv_c;
      if (inv_m < k) k = inv_m;
      if (inv_y < k) k = inv_y;
      if (k == 255) black_pixels++;
      comps = '{CompCyan, CompMagenta, CompYellow, CompBlack};
      vals  = '{scale_ink(inv_c, k), scale_ink(inv_m, k), scale_ink(inv_y, k), 8'(k)};
      for (int i = 0; i < 4; i++) begin
        beat.value = vals[i];
        beat.comp  = comps[i];
        beat.last  = (comps[i] == CompBlack);
        pending_beats.push_back(beat);
      end
      pixels_done++;
    endfunction

    function void check_beat(logic [7:0] value, logic [1:0] comp, logic last);
      cmyk_beat_t exp_beat;
      beats_seen++;
      if (pending_beats.size() == 0) begin
        $display("%0t: unexpected beat value=%0d component=%0d last=%0b",
                 $time, value, comp, last);
        errors++;
        return;
      end
      exp_beat = pending_beats.pop_front();
      if (value !== exp_beat.value) begin
        $display("%0t: out_byte mismatch, expected %0d actual %0d",
                 $time, exp_beat.value, value);
        errors++;
      end
      if (comp !== exp_beat.comp) begin
        $display("%0t: component mismatch, expected %0d actual %0d",
                 $time, exp_beat.comp, comp);
        errors++;
      end
      if (last !== exp_beat.last) begin
        $display("%0t: last mismatch, expected %0b actual %0b",
                 $time, exp_beat.last, last);
        errors++;
      end
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_byte = 8'd0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_byte;
  logic [1:0] component;
  logic       last;

  logic        calm = 1'b0;
  int unsigned stall_left = 0;

  cmyk_scoreboard sb = new();

  rgb_to_cmyk_byte_stream_core dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_byte   (in_byte),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .component (component),
    .last      (last)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Receiver: stall out_ready in random bursts until the calm tail.
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 12);
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      sb.check_beat(out_byte, component, last);
    end
  end

  // Hold the beat until it is taken; the caller decides whether to drop valid.
  task automatic push_byte(logic [7:0] b);
    in_valid <= 1'b1;
    in_byte  <= b;
    do @(posedge clk); while (!in_ready);
    sb.note_byte(b);
  endtask

  task automatic maybe_idle();
    int unsigned gap;
    if (!calm && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 13);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 9))
      0: return 8'd0;
      1: return 8'd255;
      2: return 8'($urandom_range(250, 255));
      3: return 8'($urandom_range(0, 5));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  localparam int DirPixels = 8;
  localparam int RandPixels = 36;
  localparam int CalmPixels = 10;

  initial begin
    logic [7:0] dir_rgb[DirPixels][3];
    logic [7:0] pix[3];
    logic [7:0] gray;
    dir_rgb = '{
      '{8'd0,   8'd0,   8'd0},    // black pixel
      '{8'd255, 8'd255, 8'd255},  // white
      '{8'd255, 8'd0,   8'd0},
      '{8'd0,   8'd255, 8'd0},
      '{8'd0,   8'd0,   8'd255},
      '{8'd1,   8'd1,   8'd1},    // K one below full scale
      '{8'd254, 8'd0,   8'd0},
      '{8'hAA,  8'h55,  8'h01}
    };

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int p = 0; p < DirPixels; p++) begin
      for (int j = 0; j < 3; j++) begin
        maybe_idle();
        push_byte(dir_rgb[p][j]);
      end
    end

    for (int p = 0; p < RandPixels; p++) begin
      if (p == RandPixels - CalmPixels) begin
        calm <= 1'b1;
      end
      if ($urandom_range(0, 7) == 0) begin
        gray = 8'($urandom_range(0, 255));
        pix  = '{gray, gray, gray};
      end else begin
        pix = '{pick_byte(), pick_byte(), pick_byte()};
      end
      for (int j = 0; j < 3; j++) begin
        maybe_idle();
        push_byte(pix[j]);
      end
    end
    in_valid <= 1'b0;

    while (sb.pending_beats.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);

    $display("covered %0d pixels (%0d full black), %0d output beats checked",
             sb.pixels_done, sb.black_pixels, sb.beats_seen);
    $display("input and output stalls in bursts, calm tail of %0d pixels", CalmPixels);
    if (sb.errors == 0) begin
      $display("tb_rgb_to_cmyk_byte_stream_core: done, clean");
    end else begin
      $display("tb_rgb_to_cmyk_byte_stream_core: done, errors");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("timeout with %0d beats outstanding", sb.pending_beats.size());
    $display("tb_rgb_to_cmyk_byte_stream_core: done, errors");
    $finish;
  end

endmodule
